// ===== hdl/latest_frame_slot_manager_unit_macros.svh =====
// Assertion macros for the slot manager RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef LATEST_FRAME_SLOT_MANAGER_UNIT_MACROS_SVH
`define LATEST_FRAME_SLOT_MANAGER_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LFSM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LFSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/lfsm_pkg.sv =====
// Package for the latest-frame slot manager: sizes, codes, record types, a saturating increment.
// Depends on nothing.
`default_nettype none
package lfsm_pkg;
  localparam int NumSlots     = 4;
  localparam int MaxConsumers = 8;
  localparam int SeqBits      = 48;
  localparam int SlotW        = $clog2(NumSlots);
  localparam int CidW         = $clog2(MaxConsumers);
  localparam int CntW         = $clog2(NumSlots + 1);
  localparam logic [31:0] ResetCapacity = 32'd1048576;
  localparam logic [3:0]  HoldMax       = 4'd15;

  localparam logic [1:0] ReqPublish = 2'd0;
  localparam logic [1:0] ReqAcquire = 2'd1;
  localparam logic [1:0] ReqRelease = 2'd2;
  localparam logic [1:0] ReqStop    = 2'd3;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StDropped = 3'd1;
  localparam logic [2:0] StTooBig  = 3'd2;
  localparam logic [2:0] StStopped = 3'd3;
  localparam logic [2:0] StBadCons = 3'd4;
  localparam logic [2:0] StNoNew   = 3'd5;

  localparam logic CfgNumConsumers = 1'b0;
  localparam logic CfgFrameCap     = 1'b1;

  // Per-slot record held in the slot memory.
  typedef struct packed {
    logic [SeqBits-1:0] seq;
    logic [31:0]        len;
    logic [63:0]        tstamp;
  } slot_rec_t;

  // Per-consumer record held in the consumer memory.
  typedef struct packed {
    logic [SeqBits-1:0] cursor;
    logic [31:0]        skips;
  } cons_rec_t;

  // Read/write request from the controller to one memory.
  typedef struct packed {
    logic                re;
    logic                we;
    logic [CidW-1:0]     addr;
  } mem_ctl_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] a);
    return (a == '1) ? a : a + 32'd1;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/lfsm_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none
module lfsm_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/lfsm_ctrl.sv =====
// Request sequencer: holds slot bookkeeping in flip-flops and drives the
// slot and consumer memories. Depends on lfsm_pkg and the macros header.
`default_nettype none
`include "latest_frame_slot_manager_unit_macros.svh"
module lfsm_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          req_valid_i,
  output logic                               req_ready_o,
  input  wire logic [1:0]                    req_type_i,
  input  wire logic [2:0]                    consumer_id_i,
  input  wire logic [1:0]                    slot_id_i,
  input  wire logic [31:0]                   byte_count_i,
  input  wire logic [63:0]                   timestamp_i,
  input  wire logic [3:0]                    num_consumers_i,
  input  wire logic [31:0]                   frame_capacity_i,
  output lfsm_pkg::mem_ctl_t                 slot_ctl_o,
  output lfsm_pkg::slot_rec_t                slot_wdata_o,
  input  wire lfsm_pkg::slot_rec_t           slot_rdata_i,
  output lfsm_pkg::mem_ctl_t                 cons_ctl_o,
  output lfsm_pkg::cons_rec_t                cons_wdata_o,
  input  wire lfsm_pkg::cons_rec_t           cons_rdata_i,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output logic [250:0]                       res_data_o
);
  import lfsm_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SRead = 2'd1;
  localparam logic [1:0] SOut  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [1:0] req_q;
  logic [CidW-1:0] cid_q;
  logic [1:0] sid_q;
  logic [31:0] bytes_q;
  logic [63:0] ts_q;
  logic [3:0] hold_q [NumSlots];
  logic [3:0] hold_d [NumSlots];
  logic newest_valid_q, newest_valid_d;
  logic [SlotW-1:0] newest_slot_q, newest_slot_d;
  logic [SeqBits-1:0] newest_seq_q, newest_seq_d, seq_q, seq_d;
  logic [CntW-1:0] inuse_q, inuse_d, peak_q, peak_d;
  logic running_q, running_d;
  logic [31:0] drops_q, drops_d, pubs_q, pubs_d;
  logic [NumSlots-1:0] slot_init_q, slot_init_d;
  logic res_valid_q;
  logic [250:0] res_q, res_d;

  logic [2:0] status;
  logic [SlotW-1:0] gslot;
  logic [SeqBits-1:0] fseq;
  logic [31:0] flen, skips_out;
  logic [63:0] ftime;
  logic free_found;
  logic [SlotW-1:0] free_slot;
  logic [3:0] ncap;
  logic bad_cid;
  logic [SeqBits-1:0] diff;
  logic [31:0] skips_new;

  assign req_ready_o = (state_q == SIdle) && !res_valid_q;
  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_q;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (hold_q[i] == 4'd0 && !(newest_valid_q && newest_slot_q == SlotW'(i))) begin
        free_found = 1'b1;
        free_slot  = SlotW'(i);
      end
    end
  end

  assign ncap    = (num_consumers_i > 4'(MaxConsumers)) ? 4'(MaxConsumers) : num_consumers_i;
  assign bad_cid = {1'b0, cid_q} >= ncap;
  assign diff    = newest_seq_q - cons_rdata_i.cursor - SeqBits'(1);
  always_comb begin
    logic [SeqBits:0] s;
    s = {1'b0, diff} + {{(SeqBits-31){1'b0}}, cons_rdata_i.skips};
    skips_new = (s > (SeqBits+1)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : s[31:0];
  end

  // The slot record and cursor reads are issued in the same cycle as acceptance.
  always_comb begin
    slot_ctl_o   = '0;
    cons_ctl_o   = '0;
    slot_wdata_o = '{seq: seq_q + SeqBits'(1), len: bytes_q, tstamp: ts_q};
    cons_wdata_o = '{cursor: newest_seq_q, skips: skips_new};
    if (state_q == SIdle && req_valid_i && req_ready_o) begin
      cons_ctl_o.re   = 1'b1;
      cons_ctl_o.addr = consumer_id_i;
      slot_ctl_o.re   = 1'b1;
      slot_ctl_o.addr = CidW'(newest_slot_q);
    end
    if (state_q == SRead) begin
      cons_ctl_o.addr = cid_q;
      slot_ctl_o.addr = CidW'(free_slot);
    end
    state_d        = state_q;
    hold_d         = hold_q;
    newest_valid_d = newest_valid_q;
    newest_slot_d  = newest_slot_q;
    newest_seq_d   = newest_seq_q;
    seq_d          = seq_q;
    inuse_d        = inuse_q;
    peak_d         = peak_q;
    running_d      = running_q;
    drops_d        = drops_q;
    pubs_d         = pubs_q;
    slot_init_d    = slot_init_q;
    status = StOk; gslot = '0; fseq = '0; flen = '0; ftime = '0;
    skips_out = '0;
    res_d  = res_q;
    case (state_q)
      SIdle: begin
        if (req_valid_i && req_ready_o) begin
          state_d = SRead;
        end
      end
      SRead: begin
        state_d = SOut;
        case (req_q)
          ReqPublish: begin
            if (!running_q) begin
              status = StStopped;
            end else if (!free_found) begin
              status  = StDropped;
              drops_d = sat_inc(drops_q);
            end else if (bytes_q > frame_capacity_i) begin
              status = StTooBig;
            end else begin
              slot_ctl_o.we = 1'b1;
              slot_init_d[free_slot] = 1'b1;
              inuse_d = inuse_q + CntW'(1);
              if (inuse_d > peak_q) peak_d = inuse_d;
              seq_d = seq_q + SeqBits'(1);
              if (newest_valid_q && hold_q[newest_slot_q] == 4'd0)
                inuse_d = inuse_d - CntW'(1);
              newest_valid_d = 1'b1;
              newest_slot_d  = free_slot;
              newest_seq_d   = seq_d;
              pubs_d = sat_inc(pubs_q);
              gslot  = free_slot;
              fseq   = seq_d;
            end
          end
          ReqAcquire: begin
            if (bad_cid) begin
              status = StBadCons;
            end else if (!running_q) begin
              status = StStopped;
            end else if (!newest_valid_q || newest_seq_q <= cons_rdata_i.cursor) begin
              status = StNoNew;
            end else begin
              if (hold_q[newest_slot_q] < HoldMax)
                hold_d[newest_slot_q] = hold_q[newest_slot_q] + 4'd1;
              cons_ctl_o.we = 1'b1;
              gslot = newest_slot_q;
              fseq  = newest_seq_q;
              flen  = slot_init_q[newest_slot_q] ? slot_rdata_i.len : ResetCapacity;
              ftime = slot_init_q[newest_slot_q] ? slot_rdata_i.tstamp : 64'd0;
            end
          end
          ReqRelease: begin
            if (hold_q[sid_q] != 4'd0) begin
              hold_d[sid_q] = hold_q[sid_q] - 4'd1;
              if (hold_d[sid_q] == 4'd0 &&
                  !(newest_valid_q && newest_slot_q == sid_q) && inuse_q != '0)
                inuse_d = inuse_q - CntW'(1);
            end
          end
          default: running_d = 1'b0;
        endcase
        skips_out = (cons_ctl_o.we) ? skips_new : cons_rdata_i.skips;
        res_d = {pubs_d, skips_out, drops_d, peak_d, inuse_d, ftime, flen, fseq, gslot, status};
      end
      SOut: begin
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      for (int i = 0; i < NumSlots; i++) hold_q[i] <= 4'd0;
      newest_valid_q <= 1'b0;
      newest_slot_q  <= '0;
      newest_seq_q   <= '0;
      seq_q          <= '0;
      inuse_q        <= '0;
      peak_q         <= '0;
      running_q      <= 1'b1;
      drops_q        <= '0;
      pubs_q         <= '0;
      slot_init_q    <= '0;
      res_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      hold_q         <= hold_d;
      newest_valid_q <= newest_valid_d;
      newest_slot_q  <= newest_slot_d;
      newest_seq_q   <= newest_seq_d;
      seq_q          <= seq_d;
      inuse_q        <= inuse_d;
      peak_q         <= peak_d;
      running_q      <= running_d;
      drops_q        <= drops_d;
      pubs_q         <= pubs_d;
      slot_init_q    <= slot_init_d;
      if (state_q == SRead) res_valid_q <= 1'b1;
      else if (res_ready_i) res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      req_q   <= req_type_i;
      cid_q   <= consumer_id_i;
      sid_q   <= slot_id_i;
      bytes_q <= byte_count_i;
      ts_q    <= timestamp_i;
    end
    res_q <= res_d;
  end

  `LFSM_ASSERT_IMPL(a_peak_ge_inuse, 1'b1, peak_q >= inuse_q)
  `LFSM_ASSERT_NEXT(a_read_then_out, state_q == SRead, res_valid_q)
  `LFSM_ASSERT_IMPL(a_no_accept_busy, res_valid_q, !req_ready_o)
endmodule
`default_nettype wire

// ===== hdl/latest_frame_slot_manager_unit.sv =====
// Latest-frame slot manager. Each request is accepted, then passes through a
// memory read state and a result state; the next request is taken once the
// result transfer has completed, so a wait on m_axis_tready also holds off the
// next request. The slot and consumer memories have registered read data.
// Slot records are read before being written, and slots never written read
// back as length 1048576 and time zero.
`default_nettype none
module latest_frame_slot_manager_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: req_type[1:0], consumer_id[4:2], slot_id[6:5], byte_count[38:7],
  // timestamp[102:39], zero pad to 104 bits.
  input  wire logic [103:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: status, granted_slot, frame_seq, frame_length, frame_time,
  // slots_in_use, peak_slots_in_use, drop_count, consumer_skip_count,
  // publish_count, zero pad to 256 bits.
  output logic [255:0]      m_axis_tdata,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic         cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);
  import lfsm_pkg::*;

  logic [3:0]  num_cons_q;
  logic [31:0] cap_q;
  mem_ctl_t slot_ctl, cons_ctl;
  slot_rec_t slot_wd, slot_rd;
  cons_rec_t cons_wd, cons_rd;
  logic [250:0] res;
  logic cons_init_q [MaxConsumers];
  cons_rec_t cons_raw;
  logic cons_rd_ok_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cons_q <= 4'd1;
      cap_q      <= ResetCapacity;
      for (int i = 0; i < MaxConsumers; i++) cons_init_q[i] <= 1'b0;
      cons_rd_ok_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgNumConsumers: num_cons_q <= cfg_data_i[3:0];
          default:         cap_q      <= cfg_data_i;
        endcase
      end
      if (cons_ctl.we) cons_init_q[cons_ctl.addr] <= 1'b1;
      if (cons_ctl.re) cons_rd_ok_q <= cons_init_q[cons_ctl.addr];
    end
  end
  assign cons_rd = cons_rd_ok_q ? cons_raw : '0;

  lfsm_ram #(.Width($bits(slot_rec_t)), .Depth(NumSlots)) u_slot_ram (
    .clk_i, .we_i(slot_ctl.we), .re_i(slot_ctl.re),
    .addr_i(slot_ctl.addr[SlotW-1:0]), .wdata_i(slot_wd), .rdata_o(slot_rd));
  lfsm_ram #(.Width($bits(cons_rec_t)), .Depth(MaxConsumers)) u_cons_ram (
    .clk_i, .we_i(cons_ctl.we), .re_i(cons_ctl.re),
    .addr_i(cons_ctl.addr), .wdata_i(cons_wd), .rdata_o(cons_raw));

  lfsm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i(s_axis_tvalid), .req_ready_o(s_axis_tready),
    .req_type_i(s_axis_tdata[1:0]), .consumer_id_i(s_axis_tdata[4:2]),
    .slot_id_i(s_axis_tdata[6:5]), .byte_count_i(s_axis_tdata[38:7]),
    .timestamp_i(s_axis_tdata[102:39]),
    .num_consumers_i(num_cons_q), .frame_capacity_i(cap_q),
    .slot_ctl_o(slot_ctl), .slot_wdata_o(slot_wd), .slot_rdata_i(slot_rd),
    .cons_ctl_o(cons_ctl), .cons_wdata_o(cons_wd), .cons_rdata_i(cons_rd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_data_o(res));

  assign m_axis_tdata = {5'b00000, res};
endmodule
`default_nettype wire
